// File: sv/rrss_pkg.sv
// Shared types and constants for the round-robin slice scheduler.
package rrss_pkg;
    localparam int MaxTasks  = 16;
    localparam int TimeBits  = 23;
    localparam int IdxBits   = $clog2(MaxTasks);
    localparam int CntBits   = IdxBits + 1;
    localparam logic [TimeBits-1:0] TimeMax = '1;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_RUN   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] arr_time;
        logic [15:0] burst_length;
    } t_rrss_in;

    typedef struct packed {
        logic                is_idle;
        logic [5:0]          task_index;
        logic [TimeBits-1:0] slice_start;
        logic [TimeBits-1:0] slice_end;
        logic                task_finished;
        logic [TimeBits-1:0] turnaround;
        logic [TimeBits-1:0] waiting;
        logic                all_done;
    } t_rrss_out;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic clear;
        logic start_load;
        logic start_run;
        logic set_all_done;
        logic load_step;
        logic queue_step;
        logic push_pre;
        logic dispatch;
        logic idle_step;
        logic idle_fin;
        logic turn;
        logic wait_calc;
    } t_rrss_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic full;
        logic all_done;
        logic load_stop;
        logic idx_last;
        logic ring_empty;
    } t_rrss_stat;
endpackage

// File: sv/rrss_ctrl.sv
// Sequencer for the round-robin slice scheduler.
module rrss_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_opcode,
    input  rrss_pkg::t_rrss_stat i_stat,
    output rrss_pkg::t_rrss_cmd  o_cmd,
    output logic                o_busy,
    output logic                o_valid
);
    import rrss_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_LOAD  = 10'b0000000010,
        S_QSCAN = 10'b0000000100,
        S_PRE   = 10'b0000001000,
        S_DISP  = 10'b0000010000,
        S_ISCAN = 10'b0000100000,
        S_IFIN  = 10'b0001000000,
        S_TURN  = 10'b0010000000,
        S_WAITR = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    case (i_opcode)
                        OP_LOAD: begin
                            if (!i_stat.full) begin
                                o_cmd.start_load = 1'b1;
                                n_state = S_LOAD;
                            end
                        end
                        OP_RUN: begin
                            if (i_stat.all_done) begin
                                o_cmd.set_all_done = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                o_cmd.start_run = 1'b1;
                                n_state = S_QSCAN;
                            end
                        end
                        OP_CLEAR: o_cmd.clear = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load_step = 1'b1;
                if (i_stat.load_stop) n_state = S_IDLE;
            end
            S_QSCAN: begin
                o_cmd.queue_step = 1'b1;
                if (i_stat.idx_last) n_state = S_PRE;
            end
            S_PRE: begin
                o_cmd.push_pre = 1'b1;
                n_state = S_DISP;
            end
            S_DISP: begin
                o_cmd.dispatch = 1'b1;
                n_state = i_stat.ring_empty ? S_ISCAN : S_TURN;
            end
            S_ISCAN: begin
                o_cmd.idle_step = 1'b1;
                if (i_stat.idx_last) n_state = S_IFIN;
            end
            S_IFIN: begin
                o_cmd.idle_fin = 1'b1;
                n_state = S_OUT;
            end
            S_TURN: begin
                o_cmd.turn = 1'b1;
                n_state = S_WAITR;
            end
            S_WAITR: begin
                o_cmd.wait_calc = 1'b1;
                n_state = S_OUT;
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result shown twice");
    a_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state != S_IDLE) |-> 1'b0) else $error("accept while busy");
endmodule

// File: sv/rrss_dp.sv
// Task tables, ready ring and slice arithmetic of the scheduler.
module rrss_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rrss_pkg::t_rrss_cmd  i_cmd,
    input  rrss_pkg::t_rrss_in   i_item,
    input  logic [15:0]          i_tq,
    output rrss_pkg::t_rrss_stat o_stat,
    output rrss_pkg::t_rrss_out  o_result
);
    import rrss_pkg::*;

    logic [15:0]        arr_mem [MaxTasks];
    logic [15:0]        bst_mem [MaxTasks];
    logic [15:0]        rem_mem [MaxTasks];
    logic [IdxBits-1:0] ord_mem [MaxTasks];
    logic [IdxBits-1:0] ring_mem[MaxTasks];

    logic [MaxTasks-1:0] r_queued, r_fin;
    logic [IdxBits-1:0]  r_head, r_pre_i, r_task;
    logic [CntBits-1:0]  r_rcnt, r_tcnt, r_fcnt, r_idx;
    logic                r_pre_v, r_finflag;
    logic [TimeBits-1:0] r_now, r_next, r_start, r_end, r_ta;
    logic [15:0]         r_arr;
    t_rrss_out           r_res;

    logic [IdxBits-1:0]  prev_ord, cur_ord, arr_addr, push_val, pop_t;
    logic [15:0]         arr_rd, rem_rd, tq_eff;
    logic                push_en, rem_le;
    logic [TimeBits:0]   sum;
    logic [TimeBits-1:0] end_sat, wt;

    assign prev_ord = ord_mem[r_idx[IdxBits-1:0] - 1'b1];
    assign cur_ord  = ord_mem[r_idx[IdxBits-1:0]];
    assign pop_t    = ring_mem[r_head];
    assign rem_rd   = rem_mem[pop_t];
    assign tq_eff   = (i_tq == 16'd0) ? 16'd1 : i_tq;
    assign rem_le   = (rem_rd <= tq_eff);

    // Select the one arrival read address
    always_comb begin
        arr_addr = r_task;
        if (i_cmd.load_step)       arr_addr = prev_ord;
        else if (i_cmd.queue_step) arr_addr = cur_ord;
        else if (i_cmd.idle_step)  arr_addr = r_idx[IdxBits-1:0];
    end
    assign arr_rd = arr_mem[arr_addr];

    // Decide ring pushes
    always_comb begin
        push_en  = 1'b0;
        push_val = cur_ord;
        if (i_cmd.queue_step) begin
            push_en = ({{(TimeBits-16){1'b0}}, arr_rd} <= r_now) && !r_queued[cur_ord]
                      && (r_rcnt < CntBits'(MaxTasks));
        end else if (i_cmd.push_pre) begin
            push_en  = r_pre_v && (r_rcnt < CntBits'(MaxTasks));
            push_val = r_pre_i;
        end
    end

    // Saturating slice end
    assign sum = {1'b0, r_now} + {{(TimeBits-15){1'b0}}, (rem_le ? rem_rd : tq_eff)};
    assign end_sat = sum[TimeBits] ? TimeMax : sum[TimeBits-1:0];
    assign wt = (r_ta >= {{(TimeBits-16){1'b0}}, bst_mem[r_task]})
              ? r_ta - {{(TimeBits-16){1'b0}}, bst_mem[r_task]} : '0;

    // Table and ring storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_load) begin
            arr_mem[r_tcnt[IdxBits-1:0]] <= i_item.arr_time;
            bst_mem[r_tcnt[IdxBits-1:0]] <= i_item.burst_length;
            rem_mem[r_tcnt[IdxBits-1:0]] <= i_item.burst_length;
        end
        if (i_cmd.load_step) begin
            if (o_stat.load_stop) ord_mem[r_idx[IdxBits-1:0]] <= r_tcnt[IdxBits-1:0];
            else                  ord_mem[r_idx[IdxBits-1:0]] <= prev_ord;
        end
        if (push_en) ring_mem[r_head + r_rcnt[IdxBits-1:0]] <= push_val;
        if (i_cmd.dispatch && r_rcnt != '0)
            rem_mem[pop_t] <= rem_le ? 16'd0 : rem_rd - tq_eff;
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_load) r_arr <= i_item.arr_time;
        if (i_cmd.dispatch) begin
            r_task    <= pop_t;
            r_start   <= r_now;
            r_end     <= end_sat;
            r_finflag <= rem_le;
            r_next    <= TimeMax;
        end
        if (i_cmd.idle_step && !r_queued[r_idx[IdxBits-1:0]]
            && {{(TimeBits-16){1'b0}}, arr_rd} < r_next)
            r_next <= {{(TimeBits-16){1'b0}}, arr_rd};
        if (i_cmd.turn)
            r_ta <= (r_end >= {{(TimeBits-16){1'b0}}, arr_rd})
                  ? r_end - {{(TimeBits-16){1'b0}}, arr_rd} : '0;
        if (i_cmd.set_all_done) begin
            r_res          <= '0;
            r_res.all_done <= 1'b1;
        end
        if (i_cmd.wait_calc) begin
            r_res               <= '0;
            r_res.task_index    <= 6'(r_task);
            r_res.slice_start   <= r_start;
            r_res.slice_end     <= r_end;
            r_res.task_finished <= r_finflag;
            r_res.turnaround    <= r_finflag ? r_ta : '0;
            r_res.waiting       <= r_finflag ? wt : '0;
        end
        if (i_cmd.idle_fin) begin
            r_res             <= '0;
            r_res.is_idle     <= 1'b1;
            r_res.slice_start <= r_now;
            r_res.slice_end   <= (r_next < r_now) ? r_now : r_next;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_queued <= '0;
            r_fin    <= '0;
            r_head   <= '0;
            r_rcnt   <= '0;
            r_tcnt   <= '0;
            r_fcnt   <= '0;
            r_idx    <= '0;
            r_now    <= '0;
            r_pre_v  <= 1'b0;
            r_pre_i  <= '0;
        end else begin
            if (i_cmd.start_load) begin
                r_queued[r_tcnt[IdxBits-1:0]] <= 1'b0;
                r_fin[r_tcnt[IdxBits-1:0]]    <= 1'b0;
                r_idx <= r_tcnt;
            end
            if (i_cmd.load_step) begin
                if (o_stat.load_stop) r_tcnt <= r_tcnt + 1'b1;
                else                  r_idx  <= r_idx - 1'b1;
            end
            if (i_cmd.start_run) r_idx <= '0;
            if (i_cmd.queue_step) begin
                r_idx <= r_idx + 1'b1;
                if (push_en) r_queued[cur_ord] <= 1'b1;
            end
            if (push_en) r_rcnt <= r_rcnt + 1'b1;
            if (i_cmd.push_pre) r_pre_v <= 1'b0;
            if (i_cmd.idle_step) r_idx <= r_idx + 1'b1;
            if (i_cmd.idle_fin) r_now <= (r_next < r_now) ? r_now : r_next;
            if (i_cmd.dispatch) begin
                if (r_rcnt == '0) begin
                    r_idx <= '0;
                end else begin
                    r_head <= r_head + 1'b1;
                    r_rcnt <= r_rcnt - 1'b1;
                    r_now  <= end_sat;
                    if (rem_le) begin
                        r_fin[pop_t] <= 1'b1;
                        r_fcnt       <= r_fcnt + 1'b1;
                    end else begin
                        r_pre_v <= 1'b1;
                        r_pre_i <= pop_t;
                    end
                end
            end
        end
    end

    assign o_stat.full       = (r_tcnt == CntBits'(MaxTasks));
    assign o_stat.all_done   = (r_fcnt == r_tcnt);
    assign o_stat.load_stop  = (r_idx == '0) || (arr_rd <= r_arr);
    assign o_stat.idx_last   = (r_idx == r_tcnt - 1'b1);
    assign o_stat.ring_empty = (r_rcnt == '0);
    assign o_result          = r_res;

    a_ring_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rcnt <= CntBits'(MaxTasks)) else $error("ring overfull");
    a_fin_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_tcnt) else $error("finished count above task count");
    a_fin_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_fin) == int'(r_fcnt)) else $error("finished flags disagree");
endmodule

// File: sv/round_robin_slice_scheduler_unit.sv
// Top level of the round-robin slice scheduler with its configuration port.
//
// Commands enter on i_item when start is high and busy is low: load a task
// (arrival, burst), request the next slice, or clear the task table.
// Each slice request gives one result on o_result, marked by o_valid for
// exactly one cycle; loads, clears and unused opcodes give none.
// A slice request first passes over the sorted task table, one entry a
// cycle, then queues the preempted task and dispatches; a slice then
// computes turnaround and waiting, an idle gap a second pass over the
// table and a finishing step. An all-done answer shows in the very next
// cycle. A load shifts table entries for its sorted insertion, one a cycle.
// The receiver cannot stall: the result must be taken in its cycle.
// time_quantum sits at byte address 0 of the APB port; write it only while
// busy is low. Reset (i_rst_n low, synchronous) empties the table, sets
// time to zero and time_quantum to 1.
module round_robin_slice_scheduler_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  rrss_pkg::t_rrss_in  i_item,
    output logic                o_valid,
    output rrss_pkg::t_rrss_out o_result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import rrss_pkg::*;

    t_rrss_cmd   cmd;
    t_rrss_stat  stat;
    logic [15:0] r_tq;
    logic        accept;

    assign accept = start && !busy;
    assign pready = 1'b1;

    // Hold the quantum register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tq <= 16'd1;
        else if (psel && penable && pwrite && !paddr[2]) r_tq <= pwdata[15:0];
    end

    assign prdata = paddr[2] ? 32'd0 : {16'd0, r_tq};

    rrss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_opcode (i_item.opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    rrss_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .i_tq     (r_tq),
        .o_stat   (stat),
        .o_result (o_result)
    );
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the round-robin slice scheduler unit.
`timescale 1ns / 100ps
module tb_top;
    import rrss_pkg::*;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    t_rrss_in        i_item;
    logic            o_valid;
    t_rrss_out       o_result;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [2:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    localparam logic [2:0] ADDR_QUANTUM = 3'd0;
    localparam int CYCLE_LIMIT = 2000000;

    round_robin_slice_scheduler_unit DUT (.*);

    // Scheduler shadow state
    logic [15:0]         sh_quantum;
    logic [15:0]         sh_arrival [MaxTasks];
    logic [15:0]         sh_burst   [MaxTasks];
    logic [15:0]         sh_remain  [MaxTasks];
    int                  sh_order   [MaxTasks];
    bit                  sh_queued  [MaxTasks];
    bit                  sh_done    [MaxTasks];
    int                  sh_ring    [$];
    int                  sh_count;
    logic [TimeBits-1:0] sh_now;
    bit                  sh_pre_valid;
    int                  sh_pre_idx;

    t_rrss_out slice_queue [$];
    int        err_count;
    longint    cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort on runaway simulation
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        err_count++;
    endtask

    function automatic void clear_shadow();
        sh_ring.delete();
        sh_count = 0;
        sh_now = '0;
        sh_pre_valid = 0;
        sh_pre_idx = 0;
        for (int i = 0; i < MaxTasks; i++) begin
            sh_queued[i] = 0;
            sh_done[i] = 0;
        end
    endfunction

    function automatic void load_shadow(logic [15:0] arr, logic [15:0] bl);
        int pos;
        pos = 0;
        if (sh_count >= MaxTasks) return;
        sh_arrival[sh_count] = arr;
        sh_burst[sh_count] = bl;
        sh_remain[sh_count] = bl;
        sh_queued[sh_count] = 0;
        sh_done[sh_count] = 0;
        while (pos < sh_count && sh_arrival[sh_order[pos]] <= arr) pos++;
        for (int k = sh_count; k > pos; k--) sh_order[k] = sh_order[k-1];
        sh_order[pos] = sh_count;
        sh_count++;
    endfunction

    function automatic t_rrss_out predict_slice();
        t_rrss_out r;
        bit all_fin;
        int t;
        logic [TimeBits:0] sum;
        logic [TimeBits-1:0] nxt, fin_t, ta;
        logic [15:0] q;
        r = '0;
        all_fin = 1;
        for (int g = 0; g < sh_count; g++) if (!sh_done[g]) all_fin = 0;
        if (all_fin) begin
            r.all_done = 1'b1;
            return r;
        end
        // Queue new arrivals in sorted order, then the preempted task
        for (int g = 0; g < sh_count; g++) begin
            t = sh_order[g];
            if (TimeBits'(sh_arrival[t]) <= sh_now && !sh_queued[t]) begin
                sh_ring.push_back(t);
                sh_queued[t] = 1;
            end
        end
        if (sh_pre_valid) begin
            sh_ring.push_back(sh_pre_idx);
            sh_pre_valid = 0;
        end
        r.slice_start = sh_now;
        if (sh_ring.size() == 0) begin
            nxt = TimeMax;
            for (int g = 0; g < sh_count; g++)
                if (!sh_queued[g] && TimeBits'(sh_arrival[g]) < nxt)
                    nxt = TimeBits'(sh_arrival[g]);
            if (nxt < sh_now) nxt = sh_now;
            sh_now = nxt;
            r.is_idle = 1'b1;
            r.slice_end = nxt;
            return r;
        end
        t = sh_ring.pop_front();
        q = (sh_quantum == 0) ? 16'd1 : sh_quantum;
        if (sh_remain[t] <= q) begin
            sum = {1'b0, sh_now} + sh_remain[t];
            fin_t = sum > TimeMax ? TimeMax : sum[TimeBits-1:0];
            sh_remain[t] = 0;
            sh_done[t] = 1;
            ta = fin_t >= sh_arrival[t] ? fin_t - sh_arrival[t] : '0;
            r.task_finished = 1'b1;
            r.turnaround = ta;
            r.waiting = ta >= sh_burst[t] ? ta - sh_burst[t] : '0;
        end else begin
            sum = {1'b0, sh_now} + q;
            fin_t = sum > TimeMax ? TimeMax : sum[TimeBits-1:0];
            sh_remain[t] = sh_remain[t] - q;
            sh_pre_valid = 1;
            sh_pre_idx = t;
        end
        sh_now = fin_t;
        r.task_index = 6'(t);
        r.slice_end = fin_t;
        return r;
    endfunction

    // Compare each slice against the oldest prediction
    always @(posedge i_clk) begin
        t_rrss_out exp_r;
        if (i_rst_n && o_valid) begin
            if (slice_queue.size() == 0) begin
                report_mismatch("unexpected slice");
            end else begin
                exp_r = slice_queue.pop_front();
                if (o_result.is_idle !== exp_r.is_idle) report_mismatch("is_idle");
                if (o_result.task_index !== exp_r.task_index)
                    report_mismatch($sformatf("task_index %0d exp %0d",
                        o_result.task_index, exp_r.task_index));
                if (o_result.slice_start !== exp_r.slice_start)
                    report_mismatch($sformatf("slice_start %0d exp %0d",
                        o_result.slice_start, exp_r.slice_start));
                if (o_result.slice_end !== exp_r.slice_end)
                    report_mismatch($sformatf("slice_end %0d exp %0d",
                        o_result.slice_end, exp_r.slice_end));
                if (o_result.task_finished !== exp_r.task_finished)
                    report_mismatch("task_finished");
                if (o_result.turnaround !== exp_r.turnaround)
                    report_mismatch("turnaround");
                if (o_result.waiting !== exp_r.waiting) report_mismatch("waiting");
                if (o_result.all_done !== exp_r.all_done) report_mismatch("all_done");
            end
        end
    end

    // Send one transaction after a random gap and update the prediction
    task automatic send_item(input logic [1:0] op, input logic [15:0] arr,
                             input logic [15:0] bl, input bit with_gap = 1);
        int gap;
        gap = with_gap ? $urandom_range(0, 15) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        // Step past the negedge that dropped start for the previous transaction
        repeat (gap + 1) @(negedge i_clk);
        i_item <= '{opcode: op, arr_time: arr, burst_length: bl};
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (op)
            OP_LOAD:  load_shadow(arr, bl);
            OP_RUN:   slice_queue.push_back(predict_slice());
            OP_CLEAR: clear_shadow();
            default: ;
        endcase
        @(negedge i_clk);
        start <= 1'b0;
        i_item <= '{opcode: op, arr_time: $urandom, burst_length: $urandom};
    endtask

    task automatic drain();
        while (slice_queue.size() != 0) @(negedge i_clk);
        repeat (2 * MaxTasks + 20) @(negedge i_clk);
    endtask

    task automatic write_quantum(input logic [15:0] q);
        logic [31:0] rd;
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= ADDR_QUANTUM; pwdata <= {16'(~q), q};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sh_quantum = q;
        @(negedge i_clk);
        psel <= 1; paddr <= ADDR_QUANTUM;
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        rd = prdata;
        if (rd[15:0] !== q) report_mismatch("time_quantum readback");
        @(negedge i_clk);
        psel <= 0; penable <= 0;
    endtask

    task automatic run_until_done(input int cap);
        for (int i = 0; i < cap; i++) send_item(OP_RUN, $urandom, $urandom);
    endtask

    // Empty table, zero burst, full table, ignored opcode, quantum extremes
    task automatic test_directed();
        send_item(OP_RUN, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOAD, 16'd5, 16'd0);
        send_item(OP_LOAD, 16'd0, 16'd3);
        send_item(OP_LOAD, 16'd0, 16'd2);
        send_item(2'd3, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
        run_until_done(8);
        drain();
        write_quantum(16'd0);
        send_item(OP_CLEAR, 16'h0, 16'h0);
        for (int i = 0; i < MaxTasks + 1; i++)
            send_item(OP_LOAD, 16'(i * 4), 16'(1 + i % 3), 0);
        run_until_done(6);
        drain();
        write_quantum(16'hFFFF);
        send_item(OP_CLEAR, 16'h0, 16'h0);
        send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
        run_until_done(5);
        drain();
    endtask

    // Random workloads: load a set, schedule it out, sometimes load midway
    task automatic test_random();
        int sent;
        int n;
        sent = 0;
        while (sent < 800) begin
            drain();
            case ($urandom_range(0, 4))
                0: write_quantum(16'd1);
                1: write_quantum(16'hFFFF);
                default: write_quantum(16'($urandom_range(1, 40)));
            endcase
            send_item(OP_CLEAR, $urandom, $urandom);
            n = $urandom_range(1, MaxTasks + 2);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(OP_LOAD, $urandom, $urandom);
                else
                    send_item(OP_LOAD, 16'($urandom_range(0, 120)),
                              16'($urandom_range(0, 30)));
                sent++;
            end
            for (int i = 0; i < 40; i++) begin
                case ($urandom_range(0, 19))
                    0: send_item(OP_LOAD, 16'($urandom_range(0, 200)),
                                 16'($urandom_range(0, 20)));
                    1: send_item(2'd3, $urandom, $urandom);
                    default: send_item(OP_RUN, $urandom, $urandom);
                endcase
                sent++;
            end
        end
        drain();
    endtask

    initial begin
        err_count = 0;
        sh_quantum = 16'd1;
        clear_shadow();
        for (int i = 0; i < MaxTasks; i++) sh_order[i] = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random();
        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
